// ===== sv/rbs_pkg.sv =====
// Shared types and constants for the ray/box slab intersection block.
`timescale 1ns / 1ps

package rbs_pkg;

    localparam int Q_W     = 32;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [Q_W-1:0] q_t;

    localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

    typedef struct packed {
        q_t lo;
        q_t hi;
    } interval_t;

endpackage

// ===== sv/rbs_slab_mul.sv =====
// One slab distance: floor((corner - origin) * inv / 2^FRAC_BITS), saturated.
`timescale 1ns / 1ps

module rbs_slab_mul #(
    parameter int FRAC_BITS = 16
) (
    input  rbs_pkg::q_t corner,
    input  rbs_pkg::q_t origin,
    input  rbs_pkg::q_t inv,
    output rbs_pkg::q_t distance
);

    localparam int QW   = rbs_pkg::Q_W;
    localparam int PW   = 2 * QW + 1;
    localparam int SH_W = PW - FRAC_BITS;

    logic signed [QW:0]     diff;
    logic signed [PW-1:0]   prod;
    logic signed [SH_W-1:0] shifted;
    logic                   fits;

    assign diff    = {corner[QW-1], corner} - {origin[QW-1], origin};
    assign prod    = diff * inv;
    // floor: drop fraction bits of the two's complement product
    assign shifted = prod[PW-1:FRAC_BITS];
    assign fits    = (&shifted[SH_W-1:QW-1]) || !(|shifted[SH_W-1:QW-1]);

    always_comb
    begin
        if (fits)
            distance = shifted[QW-1:0];
        else if (shifted[SH_W-1])
            distance = rbs_pkg::Q_MIN;
        else
            distance = rbs_pkg::Q_MAX;
    end

endmodule

// ===== sv/rbs_axis.sv =====
// Entry/exit interval of one axis slab, ordered by the sign of the inverse direction.
`timescale 1ns / 1ps

module rbs_axis #(
    parameter int FRAC_BITS = 16
) (
    input  rbs_pkg::q_t       box_min,
    input  rbs_pkg::q_t       box_max,
    input  rbs_pkg::q_t       origin,
    input  rbs_pkg::q_t       inv,
    output rbs_pkg::interval_t span
);

    logic        neg;
    rbs_pkg::q_t near_corner;
    rbs_pkg::q_t far_corner;

    assign neg         = inv[rbs_pkg::Q_W-1];
    assign near_corner = neg ? box_max : box_min;
    assign far_corner  = neg ? box_min : box_max;

    rbs_slab_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_lo (
        .corner   (near_corner),
        .origin   (origin),
        .inv      (inv),
        .distance (span.lo)
    );

    rbs_slab_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_hi (
        .corner   (far_corner),
        .origin   (origin),
        .inv      (inv),
        .distance (span.hi)
    );

endmodule

// ===== sv/ray_box_slab_intersect_unit.sv =====
// Ray versus axis-aligned box slab test, top level.
//
// Usage:
//   Configuration: cfg_valid/cfg_ready write cfg_data to box register cfg_index
//   (0..2 box_min x/y/z, 3..5 box_max x/y/z; other indexes ignored). cfg_ready
//   is always high. Write only while no item is in flight.
//   Input: one ray item (origin, inverse direction, start_distance) is taken at
//   each edge with in_valid high and in_stall low.
//   Output: one result (hit, t_enter, t_exit) per item, taken at each edge with
//   out_valid high and out_stall low. On a miss all result fields are zero.
//   Path: an accepted item passes the input register, then the six slab multipliers
//   and interval merge in one pass, then the result register.
//   Throughput: 1 item per cycle unless stalled; set by the one multiplier stage.
//   Stall: a stalled result holds; a new item is still taken while the input
//   register is empty, and in_stall rises only when both registers are full.
//   Reset: clears all valid flags and the box registers to zero.
`timescale 1ns / 1ps

module ray_box_slab_intersect_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  rbs_pkg::q_t                     cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  rbs_pkg::q_t                     origin_x,
    input  rbs_pkg::q_t                     origin_y,
    input  rbs_pkg::q_t                     origin_z,
    input  rbs_pkg::q_t                     inv_dir_x,
    input  rbs_pkg::q_t                     inv_dir_y,
    input  rbs_pkg::q_t                     inv_dir_z,
    input  rbs_pkg::q_t                     start_distance,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            hit,
    output rbs_pkg::q_t                     t_enter,
    output rbs_pkg::q_t                     t_exit
);

    rbs_pkg::q_t box_min_x_reg, box_min_y_reg, box_min_z_reg;
    rbs_pkg::q_t box_max_x_reg, box_max_y_reg, box_max_z_reg;

    logic        s1_valid_reg, s1_valid_next;
    rbs_pkg::q_t org_x_reg, org_y_reg, org_z_reg;
    rbs_pkg::q_t inv_x_reg, inv_y_reg, inv_z_reg;
    rbs_pkg::q_t start_reg;

    logic        out_valid_reg, out_valid_next;
    logic        hit_reg, hit_next;
    rbs_pkg::q_t t_enter_reg, t_enter_next;
    rbs_pkg::q_t t_exit_reg, t_exit_next;

    logic        out_block;
    logic        in_take;

    rbs_pkg::interval_t span_x, span_y, span_z;
    rbs_pkg::q_t        tmin1, tmax1, tmin2, tmax2;
    logic               miss1, miss2;

    assign cfg_ready = 1'b1;
    assign out_block = out_valid_reg && out_stall;
    assign in_stall  = s1_valid_reg && out_block;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_x_reg <= '0;
            box_min_y_reg <= '0;
            box_min_z_reg <= '0;
            box_max_x_reg <= '0;
            box_max_y_reg <= '0;
            box_max_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rbs_pkg::REG_BOX_MIN_X: box_min_x_reg <= cfg_data;
                rbs_pkg::REG_BOX_MIN_Y: box_min_y_reg <= cfg_data;
                rbs_pkg::REG_BOX_MIN_Z: box_min_z_reg <= cfg_data;
                rbs_pkg::REG_BOX_MAX_X: box_max_x_reg <= cfg_data;
                rbs_pkg::REG_BOX_MAX_Y: box_max_y_reg <= cfg_data;
                rbs_pkg::REG_BOX_MAX_Z: box_max_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    assign s1_valid_next = in_stall ? s1_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            org_x_reg <= origin_x;
            org_y_reg <= origin_y;
            org_z_reg <= origin_z;
            inv_x_reg <= inv_dir_x;
            inv_y_reg <= inv_dir_y;
            inv_z_reg <= inv_dir_z;
            start_reg <= start_distance;
        end
    end

    rbs_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
        .box_min (box_min_x_reg),
        .box_max (box_max_x_reg),
        .origin  (org_x_reg),
        .inv     (inv_x_reg),
        .span    (span_x)
    );

    rbs_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
        .box_min (box_min_y_reg),
        .box_max (box_max_y_reg),
        .origin  (org_y_reg),
        .inv     (inv_y_reg),
        .span    (span_y)
    );

    rbs_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
        .box_min (box_min_z_reg),
        .box_max (box_max_z_reg),
        .origin  (org_z_reg),
        .inv     (inv_z_reg),
        .span    (span_z)
    );

    // interval merge; touching intervals still overlap
    always_comb
    begin
        miss1 = (span_x.lo > span_y.hi) || (span_y.lo > span_x.hi);
        tmin1 = (span_y.lo > span_x.lo) ? span_y.lo : span_x.lo;
        tmax1 = (span_y.hi < span_x.hi) ? span_y.hi : span_x.hi;
        miss2 = (tmin1 > span_z.hi) || (span_z.lo > tmax1);
        tmin2 = (span_z.lo > tmin1) ? span_z.lo : tmin1;
        tmax2 = (span_z.hi < tmax1) ? span_z.hi : tmax1;

        hit_next     = !miss1 && !miss2 && (tmax2 > start_reg);
        t_enter_next = '0;
        t_exit_next  = '0;
        if (hit_next)
        begin
            t_enter_next = (tmin2 < start_reg) ? start_reg : tmin2;
            t_exit_next  = tmax2;
        end
    end

    // result register
    assign out_valid_next = out_block ? out_valid_reg : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (!out_block)
        begin
            hit_reg     <= hit_next;
            t_enter_reg <= t_enter_next;
            t_exit_reg  <= t_exit_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign t_enter   = t_enter_reg;
    assign t_exit    = t_exit_reg;

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("in_stall raised with a free register");

    a_item_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_block) |=> out_valid_reg)
        else $error("item lost between input and result register");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hit_reg) |-> (t_enter_reg == '0 && t_exit_reg == '0))
        else $error("miss result carries nonzero distances");

    a_hit_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && hit_next) |-> (t_exit_next > start_reg && t_enter_next >= start_reg))
        else $error("hit distances out of order against start");
`endif

endmodule
